// ===== hdl/text_console_cursor_engine_defines.svh =====
// Assertion macros for the text console cursor engine.
// Depends on nothing; the including module provides aclk and aresetn.
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// A property checked on every rising clock edge outside reset.
`define TCCE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// A condition that must be followed by an expectation in the next cycle.
`define TCCE_ASSERT_NEXT(lbl, cond, nxt, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (nxt)) \
        else $error(msg);

`else

`define TCCE_ASSERT(lbl, prop, msg)
`define TCCE_ASSERT_NEXT(lbl, cond, nxt, msg)

`endif

`endif

// ===== hdl/tcce_pkg.sv =====
// Package for the text console cursor engine: widths, constants, codes,
// the per-console state entry type and small arithmetic helpers.
// Depends on nothing.
package tcce_pkg;

    // Geometry of the console text and of the shared character memory.
    localparam int LINE_CELLS   = 80;
    localparam int SCREEN_CELLS = 2000;
    localparam int CONSOLES     = 4;
    localparam int TAB_SPACES   = 6;
    localparam int MEMORY_CELLS = 16384;
    localparam int RESULT_LIMIT = 6;
    localparam int TAB_RESULTS  = (TAB_SPACES < RESULT_LIMIT) ? TAB_SPACES : RESULT_LIMIT;

    // Field widths.
    localparam int MODE_W   = 4;
    localparam int CHAR_W   = 8;
    localparam int SEL_W    = 2;
    localparam int ATTR_W   = 8;
    localparam int CELL_W   = $clog2(MEMORY_CELLS);
    localparam int CFG_W    = 15;
    localparam int POS_W    = 15;
    localparam int WIDE_W   = POS_W + 2;
    localparam int BASE_W   = POS_W + 3;
    localparam int CONS_W   = (CONSOLES > 1) ? $clog2(CONSOLES) : 1;
    localparam int TABC_W   = (TAB_RESULTS > 1) ? $clog2(TAB_RESULTS) : 1;
    localparam int CFG_IDX_W = 2;

    // Largest region size; larger register values are clamped to it.
    localparam logic [POS_W-1:0] MAX_REGION = POS_W'(16384);

    // Reset values of the configuration registers.
    localparam logic [CFG_W-1:0]  FIRST_REGION_RESET = CFG_W'(4096);
    localparam logic [CFG_W-1:0]  OTHER_REGION_RESET = CFG_W'(4096);
    localparam logic [ATTR_W-1:0] ATTR_RESET         = ATTR_W'(7);

    localparam logic [CHAR_W-1:0] SPACE_CHAR   = CHAR_W'(8'h20);
    localparam logic [CHAR_W-1:0] NEWLINE_CHAR = CHAR_W'(8'h0A);

    // Division by the line length as a reciprocal multiplication. With a
    // shift of 23 the rounded-up reciprocal is exact for every cursor value.
    localparam int DIV_SHIFT  = 23;
    localparam int DIV_MULT   = (2**DIV_SHIFT + LINE_CELLS - 1) / LINE_CELLS;
    localparam int DIV_MULT_W = $clog2(DIV_MULT + 1);
    localparam int DIV_PROD_W = POS_W + DIV_MULT_W;
    localparam int LINE_Q_W   = POS_W + 1 - $clog2(LINE_CELLS);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FIRST_REGION = 2'd0,
        REG_OTHER_REGION = 2'd1,
        REG_TEXT_ATTR    = 2'd2
    } cfg_reg_t;

    // Operation codes of the input transaction.
    typedef enum logic [MODE_W-1:0] {
        MODE_CHAR        = 4'd0,
        MODE_NEWLINE     = 4'd1,
        MODE_BACKSPACE   = 4'd2,
        MODE_DELETE      = 4'd3,
        MODE_UP          = 4'd4,
        MODE_DOWN        = 4'd5,
        MODE_LEFT        = 4'd6,
        MODE_RIGHT       = 4'd7,
        MODE_HOME        = 4'd8,
        MODE_END         = 4'd9,
        MODE_TAB         = 4'd10,
        MODE_SCROLL_UP   = 4'd11,
        MODE_SCROLL_DOWN = 4'd12,
        MODE_SELECT      = 4'd13
    } mode_t;

    // One entry of the console state memory, relative to the region start.
    typedef struct packed {
        logic [POS_W-1:0]  cursor;
        logic [CELL_W-1:0] view;
    } con_entry_t;

    // Region size register clamped to the range one to MAX_REGION.
    function automatic logic [POS_W-1:0] clamp_region(input logic [CFG_W-1:0] v);
        logic [POS_W-1:0] r;
        if (v == '0) begin
            r = POS_W'(1);
        end else if (POS_W'(v) > MAX_REGION) begin
            r = MAX_REGION;
        end else begin
            r = POS_W'(v);
        end
        return r;
    endfunction

    // Line number of a cursor position.
    function automatic logic [LINE_Q_W-1:0] line_of(input logic [POS_W-1:0] p);
        logic [DIV_PROD_W-1:0] prod;
        prod = DIV_PROD_W'(p) * DIV_PROD_W'(DIV_MULT);
        return LINE_Q_W'(prod >> DIV_SHIFT);
    endfunction

    // The view moves down one line once the cursor is a screen past it.
    function automatic logic [CELL_W-1:0] follow_view(input logic [WIDE_W-1:0] p,
                                                      input logic [CELL_W-1:0] v);
        logic [WIDE_W-1:0] vw;
        logic [CELL_W-1:0] r;
        vw = WIDE_W'(v);
        r  = v;
        if (p >= vw && (p - vw) >= WIDE_W'(SCREEN_CELLS)) begin
            r = CELL_W'(vw + WIDE_W'(LINE_CELLS));
        end
        return r;
    endfunction

endpackage

// ===== hdl/text_console_cursor_engine.sv =====
// Text console cursor engine: per-console cursor and view state in a small
// synchronous memory, read-modify-write with forwarding, registered results.
// Depends on tcce_pkg and text_console_cursor_engine_defines.svh.
//
//  Channel  | Direction | Handshake        | Payload
//  ---------+-----------+------------------+-------------------------------------------
//  s_       | in        | s_valid/s_ready  | mode, char_code, console_select
//  m_       | out       | m_valid/m_ready  | write_*, clear_request, cursor, view, last
//  cfg_     | in        | cfg_valid/ready  | cfg_index, cfg_data (always ready)
//
// One transaction per cycle is accepted while results are taken; a tab holds the edit stage
// for six results, one result per cycle. An input is registered in the edit stage and its
// result in the result register. The rate is set by the single write port of the console
// state memory and by the one result register. Reset clears the per-console valid bits, so no
// clearing pass is needed. A stalled result holds the edit stage and the input.
`include "text_console_cursor_engine_defines.svh"

module text_console_cursor_engine (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [tcce_pkg::MODE_W-1:0]   s_mode,
    input  logic [tcce_pkg::CHAR_W-1:0]   s_char_code,
    input  logic [tcce_pkg::SEL_W-1:0]    s_console_select,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_write_enable,
    output logic [tcce_pkg::CELL_W-1:0]   m_write_address,
    output logic [tcce_pkg::CHAR_W-1:0]   m_write_char,
    output logic [tcce_pkg::ATTR_W-1:0]   m_write_attr,
    output logic                          m_clear_request,
    output logic [tcce_pkg::CELL_W-1:0]   m_cursor_cell,
    output logic [tcce_pkg::CELL_W-1:0]   m_view_start,
    output logic                          m_last,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tcce_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tcce_pkg::CFG_W-1:0]    cfg_data
);
    import tcce_pkg::*;

    // Configuration registers.
    logic [CFG_W-1:0]  first_cells_reg;
    logic [CFG_W-1:0]  other_cells_reg;
    logic [ATTR_W-1:0] attr_reg;

    // Console state memory with valid bits and forwarding of the last write.
    con_entry_t        state_mem [CONSOLES];
    logic [CONSOLES-1:0] ent_vld_reg;
    con_entry_t        rdata_reg;
    logic              rvld_reg;
    logic              fwd_valid_reg;
    logic [CONS_W-1:0] fwd_addr_reg;
    con_entry_t        fwd_data_reg;

    // Input side.
    logic [CONS_W-1:0] active_reg;
    logic              s_acc;
    logic              sel_ok;
    logic [CONS_W-1:0] raddr;

    // Edit stage.
    logic              s1_valid_reg;
    logic              s1_valid_next;
    mode_t             s1_mode_reg;
    logic [CHAR_W-1:0] s1_char_reg;
    logic [CONS_W-1:0] s1_con_reg;
    logic [TABC_W-1:0] tab_cnt_reg;
    logic [TABC_W-1:0] tab_cnt_next;
    logic              s1_fire;
    logic              s1_final;
    logic              out_free;

    // Edit stage datapath.
    con_entry_t        cur;
    logic              fwd_hit;
    logic [WIDE_W-1:0] pw;
    logic [WIDE_W-1:0] sw;
    logic [POS_W-1:0]  size;
    logic [BASE_W-1:0] base;
    logic [LINE_Q_W-1:0] line_q;
    logic [WIDE_W-1:0] line_start;
    logic [WIDE_W-1:0] next_line;
    logic [WIDE_W-1:0] cand;
    logic              move_ok;
    logic [WIDE_W-1:0] np_w;
    logic [CELL_W-1:0] nv;
    logic [WIDE_W-1:0] wpos_w;
    logic              we;
    logic [CHAR_W-1:0] wch;
    logic              clr;
    logic [CHAR_W-1:0] put_ch;
    logic              is_put;
    logic              is_newline;
    con_entry_t        wr_entry;

    // Result register.
    logic              m_valid_reg;
    logic              m_valid_next;
    logic              m_we_reg;
    logic [CELL_W-1:0] m_waddr_reg;
    logic [CHAR_W-1:0] m_wchar_reg;
    logic [ATTR_W-1:0] m_wattr_reg;
    logic              m_clr_reg;
    logic [CELL_W-1:0] m_cursor_reg;
    logic [CELL_W-1:0] m_view_reg;
    logic              m_last_reg;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_cells_reg <= FIRST_REGION_RESET;
            other_cells_reg <= OTHER_REGION_RESET;
            attr_reg        <= ATTR_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == REG_FIRST_REGION) begin
                first_cells_reg <= cfg_data;
            end
            if (cfg_index == REG_OTHER_REGION) begin
                other_cells_reg <= cfg_data;
            end
            if (cfg_index == REG_TEXT_ATTR) begin
                attr_reg <= ATTR_W'(cfg_data);
            end
        end
    end

    // Handshake control of the edit stage and the result register.
    assign out_free = !m_valid_reg || m_ready;
    assign s1_final = (s1_mode_reg != MODE_TAB) || (tab_cnt_reg == TABC_W'(TAB_RESULTS - 1));
    assign s1_fire  = s1_valid_reg && out_free;
    assign s_ready  = !s1_valid_reg || (s1_fire && s1_final);
    assign s_acc    = s_valid && s_ready;

    // A console select reads the newly selected console so that its result
    // reports that console's cursor and view.
    assign sel_ok = (mode_t'(s_mode) == MODE_SELECT) && (int'(s_console_select) < CONSOLES);
    assign raddr  = sel_ok ? CONS_W'(s_console_select) : active_reg;

    always_comb begin
        s1_valid_next = s1_valid_reg;
        tab_cnt_next  = tab_cnt_reg;
        if (s_acc) begin
            s1_valid_next = 1'b1;
            tab_cnt_next  = '0;
        end else if (s1_fire) begin
            if (s1_final) begin
                s1_valid_next = 1'b0;
                tab_cnt_next  = '0;
            end else begin
                tab_cnt_next = tab_cnt_reg + TABC_W'(1);
            end
        end
        m_valid_next = s1_fire ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            tab_cnt_reg  <= '0;
            active_reg   <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            tab_cnt_reg  <= tab_cnt_next;
            m_valid_reg  <= m_valid_next;
            if (s_acc && sel_ok) begin
                active_reg <= raddr;
            end
        end
    end

    // Edit stage payload, captured with the transaction.
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            s1_mode_reg <= mode_t'(s_mode);
            s1_char_reg <= s_char_code;
            s1_con_reg  <= raddr;
        end
    end

    // State memory read on acceptance; read data is registered.
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            rdata_reg <= state_mem[raddr];
        end
    end

    // State memory write when the edit stage hands over a result.
    always_ff @(posedge aclk) begin
        if (s1_fire) begin
            state_mem[s1_con_reg] <= wr_entry;
        end
    end

    // Valid bits and the forwarding register for the last write.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ent_vld_reg   <= '0;
            rvld_reg      <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end else begin
            if (s_acc) begin
                rvld_reg <= ent_vld_reg[raddr];
            end
            if (s1_fire) begin
                ent_vld_reg[s1_con_reg] <= 1'b1;
                fwd_valid_reg           <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_fire) begin
            fwd_addr_reg <= s1_con_reg;
            fwd_data_reg <= wr_entry;
        end
    end

    // Current state of the console: the last write wins over the read data,
    // and an entry never written reads as zero.
    assign fwd_hit = fwd_valid_reg && (fwd_addr_reg == s1_con_reg);
    assign cur     = fwd_hit ? fwd_data_reg : (rvld_reg ? rdata_reg : '0);

    // Region of the console and line arithmetic around the cursor.
    assign size = (s1_con_reg == '0) ? clamp_region(first_cells_reg)
                                     : clamp_region(other_cells_reg);
    assign base = (s1_con_reg == '0) ? '0
                : BASE_W'(clamp_region(first_cells_reg))
                  + BASE_W'(clamp_region(other_cells_reg)) * BASE_W'(s1_con_reg - CONS_W'(1));
    assign pw         = WIDE_W'(cur.cursor);
    assign sw         = WIDE_W'(size);
    assign line_q     = line_of(cur.cursor);
    assign line_start = WIDE_W'(line_q) * WIDE_W'(LINE_CELLS);
    assign next_line  = line_start + WIDE_W'(LINE_CELLS);

    // Operation decode.
    assign is_newline = (s1_mode_reg == MODE_NEWLINE)
                     || ((s1_mode_reg == MODE_CHAR) && (s1_char_reg == NEWLINE_CHAR));
    assign is_put     = ((s1_mode_reg == MODE_CHAR) && (s1_char_reg != NEWLINE_CHAR))
                     || (s1_mode_reg == MODE_TAB);
    assign put_ch     = (s1_mode_reg == MODE_TAB) ? SPACE_CHAR : s1_char_reg;

    // Next cursor, view and cell write of the active operation.
    always_comb begin
        np_w    = pw;
        nv      = cur.view;
        wpos_w  = '0;
        we      = 1'b0;
        wch     = '0;
        clr     = 1'b0;
        cand    = '0;
        move_ok = 1'b0;
        if (is_put) begin
            // A character past the region wraps the console to its start.
            if (pw >= sw) begin
                wpos_w = '0;
                nv     = '0;
                clr    = 1'b1;
            end else begin
                wpos_w = pw;
            end
            we   = 1'b1;
            wch  = put_ch;
            np_w = wpos_w + WIDE_W'(1);
            nv   = follow_view(np_w, nv);
        end else if (is_newline) begin
            if (next_line < sw) begin
                np_w = next_line;
                nv   = follow_view(next_line, cur.view);
            end else begin
                np_w = '0;
                nv   = '0;
                clr  = 1'b1;
            end
        end else begin
            unique case (s1_mode_reg)
                MODE_BACKSPACE, MODE_DELETE: begin
                    if (s1_mode_reg == MODE_BACKSPACE) begin
                        cand = (pw > '0) ? pw - WIDE_W'(1) : '0;
                    end else begin
                        cand = pw + WIDE_W'(1);
                    end
                    if (cand > sw - WIDE_W'(1)) begin
                        cand = sw - WIDE_W'(1);
                    end
                    np_w   = cand;
                    we     = 1'b1;
                    wpos_w = cand;
                    wch    = SPACE_CHAR;
                end
                MODE_UP, MODE_DOWN, MODE_LEFT, MODE_RIGHT: begin
                    // A move that would leave the region is refused.
                    if (s1_mode_reg == MODE_UP) begin
                        move_ok = pw >= WIDE_W'(LINE_CELLS);
                        cand    = pw - WIDE_W'(LINE_CELLS);
                    end else if (s1_mode_reg == MODE_DOWN) begin
                        cand    = pw + WIDE_W'(LINE_CELLS);
                        move_ok = cand < sw;
                    end else if (s1_mode_reg == MODE_LEFT) begin
                        move_ok = pw > '0;
                        cand    = pw - WIDE_W'(1);
                    end else begin
                        cand    = pw + WIDE_W'(1);
                        move_ok = cand < sw;
                    end
                    if (move_ok && cand < sw) begin
                        np_w = cand;
                        nv   = follow_view(cand, cur.view);
                    end
                end
                MODE_HOME: begin
                    np_w = line_start;
                end
                MODE_END: begin
                    cand = next_line - WIDE_W'(1);
                    if (cand > sw - WIDE_W'(1)) begin
                        cand = sw - WIDE_W'(1);
                    end
                    np_w = cand;
                end
                MODE_SCROLL_UP: begin
                    if (WIDE_W'(cur.view) >= WIDE_W'(SCREEN_CELLS)) begin
                        nv = CELL_W'(WIDE_W'(cur.view) - WIDE_W'(SCREEN_CELLS));
                    end else if (sw >= WIDE_W'(SCREEN_CELLS)) begin
                        nv = CELL_W'(sw - WIDE_W'(SCREEN_CELLS));
                    end else begin
                        nv = '0;
                    end
                end
                MODE_SCROLL_DOWN: begin
                    cand = WIDE_W'(cur.view) + WIDE_W'(SCREEN_CELLS);
                    nv   = (cand > sw) ? '0 : CELL_W'(cand);
                end
                default: begin
                    // Select and unused codes leave the state as it is.
                    np_w = pw;
                end
            endcase
        end
    end

    assign wr_entry.cursor = POS_W'(np_w);
    assign wr_entry.view   = nv;

    // Result register; absolute cells are the low bits of base plus offset.
    always_ff @(posedge aclk) begin
        if (s1_fire) begin
            m_we_reg     <= we;
            m_waddr_reg  <= we ? CELL_W'(base + BASE_W'(wpos_w)) : '0;
            m_wchar_reg  <= we ? wch : '0;
            m_wattr_reg  <= we ? attr_reg : '0;
            m_clr_reg    <= clr;
            m_cursor_reg <= CELL_W'(base + BASE_W'(np_w));
            m_view_reg   <= CELL_W'(base + BASE_W'(nv));
            m_last_reg   <= s1_final;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_write_enable  = m_we_reg;
    assign m_write_address = m_waddr_reg;
    assign m_write_char    = m_wchar_reg;
    assign m_write_attr    = m_wattr_reg;
    assign m_clear_request = m_clr_reg;
    assign m_cursor_cell   = m_cursor_reg;
    assign m_view_start    = m_view_reg;
    assign m_last          = m_last_reg;

    // The tab counter only runs while a tab sits in the edit stage.
    `TCCE_ASSERT(a_tab_cnt_owner,
        (tab_cnt_reg != '0) |-> (s1_valid_reg && s1_mode_reg == MODE_TAB),
        "tab counter running without a tab")
    // A tab that is not finished keeps the edit stage occupied.
    `TCCE_ASSERT_NEXT(a_tab_continues, s1_fire && !s1_final, s1_valid_reg,
        "tab left the edit stage early")
    // Every handed-over result updates the forwarding register for its console.
    `TCCE_ASSERT_NEXT(a_fwd_follows, s1_fire,
        fwd_valid_reg && fwd_addr_reg == $past(s1_con_reg),
        "forwarding register missed a write")
    // A stored cursor never lies beyond the largest region.
    `TCCE_ASSERT(a_cursor_range, fwd_valid_reg |-> (fwd_data_reg.cursor <= MAX_REGION),
        "stored cursor out of range")
    // Only the non-final results of a tab are not marked last, and they write.
    `TCCE_ASSERT(a_not_last_writes, (m_valid_reg && !m_last_reg) |-> m_we_reg,
        "non-final result without a write")

endmodule

// ===== tb/tcce_result_checker.sv =====
// Result checker for the text console cursor engine: watches the register, input and result
// channels, predicts every result from its own copy of the console state and compares them.
// Depends on tcce_pkg.
module tcce_result_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic [tcce_pkg::MODE_W-1:0]    s_mode,
    input  logic [tcce_pkg::CHAR_W-1:0]    s_char_code,
    input  logic [tcce_pkg::SEL_W-1:0]     s_console_select,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic                           m_write_enable,
    input  logic [tcce_pkg::CELL_W-1:0]    m_write_address,
    input  logic [tcce_pkg::CHAR_W-1:0]    m_write_char,
    input  logic [tcce_pkg::ATTR_W-1:0]    m_write_attr,
    input  logic                           m_clear_request,
    input  logic [tcce_pkg::CELL_W-1:0]    m_cursor_cell,
    input  logic [tcce_pkg::CELL_W-1:0]    m_view_start,
    input  logic                           m_last,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [tcce_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tcce_pkg::CFG_W-1:0]     cfg_data,
    output int unsigned                    error_count,
    output int unsigned                    results_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import tcce_pkg::*;

    localparam int unsigned REGION_MAX_CELLS = 16384;

    // One result transaction as the display side sees it.
    typedef struct packed {
        logic              write_enable;
        logic [CELL_W-1:0] write_address;
        logic [CHAR_W-1:0] write_char;
        logic [ATTR_W-1:0] write_attr;
        logic              clear_request;
        logic [CELL_W-1:0] cursor_cell;
        logic [CELL_W-1:0] view_start;
        logic              last;
    } console_result_t;

    // Predicted console state and register copies.
    logic [CFG_W-1:0]  first_cells;
    logic [CFG_W-1:0]  other_cells;
    logic [ATTR_W-1:0] attribute;
    logic [POS_W-1:0]  cursor_pos [CONSOLES];
    logic [CELL_W-1:0] view_off [CONSOLES];
    logic [CONS_W-1:0] active_console;

    console_result_t display_queue [$];

    // Region size with a zero register read as one and large values capped.
    function automatic int unsigned region_cells(input int unsigned con);
        int unsigned cells;
        cells = (con == 0) ? first_cells : other_cells;
        if (cells == 0) begin
            cells = 1;
        end else if (cells > REGION_MAX_CELLS) begin
            cells = REGION_MAX_CELLS;
        end
        return cells;
    endfunction

    // Regions follow each other upward from cell zero.
    function automatic int unsigned region_start(input int unsigned con);
        int unsigned start;
        start = 0;
        if (con != 0) begin
            start = region_cells(0) + (con - 1) * region_cells(1);
        end
        return start;
    endfunction

    // Absolute cell address, wrapped around the shared memory.
    function automatic logic [CELL_W-1:0] memory_cell(input int unsigned con,
                                                      input int unsigned rel);
        return CELL_W'((region_start(con) + rel) % MEMORY_CELLS);
    endfunction

    // Mismatch reporting: one line for every mismatch, and a count.
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
        error_count++;
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_mismatch(what, got, want);
        end
    endtask

    // Queue one expected result for the active console.
    task automatic queue_result(input bit write, input int unsigned rel,
                                input logic [CHAR_W-1:0] ch, input bit clear, input bit last);
        console_result_t res;
        int unsigned con;
        con = active_console;
        res.write_enable  = write;
        res.write_address = write ? memory_cell(con, rel) : '0;
        res.write_char    = write ? ch : '0;
        res.write_attr    = write ? attribute : '0;
        res.clear_request = clear;
        res.cursor_cell   = memory_cell(con, cursor_pos[con]);
        res.view_start    = memory_cell(con, view_off[con]);
        res.last          = last;
        display_queue.push_back(res);
    endtask

    // The view moves down a line once the cursor is a whole screen past it.
    task automatic track_cursor(input int unsigned con);
        int unsigned p;
        int unsigned v;
        p = cursor_pos[con];
        v = view_off[con];
        if (p >= v && p - v >= SCREEN_CELLS) begin
            view_off[con] = CELL_W'(v + LINE_CELLS);
        end
    endtask

    // A character or a newline at the cursor; running past the region wraps the console.
    task automatic put_cell(input logic [CHAR_W-1:0] ch, input bit last);
        int unsigned con;
        int unsigned cells;
        int unsigned p;
        bit clear;
        con   = active_console;
        cells = region_cells(con);
        p     = cursor_pos[con];
        clear = 1'b0;
        if (ch == NEWLINE_CHAR) begin
            p = (p / LINE_CELLS + 1) * LINE_CELLS;
            if (p < cells) begin
                cursor_pos[con] = POS_W'(p);
                track_cursor(con);
            end else begin
                cursor_pos[con] = '0;
                view_off[con]   = '0;
                clear = 1'b1;
            end
            queue_result(1'b0, 0, '0, clear, last);
        end else begin
            if (p >= cells) begin
                p = 0;
                view_off[con] = '0;
                clear = 1'b1;
            end
            cursor_pos[con] = POS_W'(p + 1);
            track_cursor(con);
            queue_result(1'b1, p, ch, clear, last);
        end
    endtask

    // Work out the results of one input transaction.
    task automatic predict_key(input logic [MODE_W-1:0] mode, input logic [CHAR_W-1:0] ch,
                               input logic [SEL_W-1:0] sel);
        int unsigned con;
        int unsigned cells;
        int unsigned p;
        int unsigned v;
        int unsigned np;
        bit moved;
        bit plain;
        con   = active_console;
        cells = region_cells(con);
        p     = cursor_pos[con];
        v     = view_off[con];
        np    = p;
        moved = 1'b0;
        plain = 1'b1;
        unique case (mode_t'(mode))
            MODE_CHAR: begin
                put_cell(ch, 1'b1);
                plain = 1'b0;
            end
            MODE_NEWLINE: begin
                put_cell(NEWLINE_CHAR, 1'b1);
                plain = 1'b0;
            end
            MODE_BACKSPACE, MODE_DELETE: begin
                if (mode == MODE_BACKSPACE) begin
                    np = (p > 0) ? p - 1 : 0;
                end else begin
                    np = p + 1;
                end
                if (np > cells - 1) begin
                    np = cells - 1;
                end
                cursor_pos[con] = POS_W'(np);
                queue_result(1'b1, np, SPACE_CHAR, 1'b0, 1'b1);
                plain = 1'b0;
            end
            MODE_UP, MODE_DOWN, MODE_LEFT, MODE_RIGHT: begin
                if (mode == MODE_UP) begin
                    moved = (p >= LINE_CELLS);
                    np = moved ? p - LINE_CELLS : p;
                end else if (mode == MODE_DOWN) begin
                    np = p + LINE_CELLS;
                    moved = (np < cells);
                end else if (mode == MODE_LEFT) begin
                    moved = (p > 0);
                    np = moved ? p - 1 : p;
                end else begin
                    np = p + 1;
                    moved = (np < cells);
                end
                // A move that would leave the region is refused.
                if (moved && np < cells) begin
                    cursor_pos[con] = POS_W'(np);
                    track_cursor(con);
                end
            end
            MODE_HOME: begin
                cursor_pos[con] = POS_W'((p / LINE_CELLS) * LINE_CELLS);
            end
            MODE_END: begin
                np = (p / LINE_CELLS + 1) * LINE_CELLS - 1;
                if (np > cells - 1) begin
                    np = cells - 1;
                end
                cursor_pos[con] = POS_W'(np);
            end
            MODE_TAB: begin
                for (int k = 0; k < TAB_RESULTS; k++) begin
                    put_cell(SPACE_CHAR, k == TAB_RESULTS - 1);
                end
                plain = 1'b0;
            end
            MODE_SCROLL_UP: begin
                if (v >= SCREEN_CELLS) begin
                    v = v - SCREEN_CELLS;
                end else begin
                    v = (cells >= SCREEN_CELLS) ? cells - SCREEN_CELLS : 0;
                end
                view_off[con] = CELL_W'(v);
            end
            MODE_SCROLL_DOWN: begin
                v = v + SCREEN_CELLS;
                if (v > cells) begin
                    v = 0;
                end
                view_off[con] = CELL_W'(v);
            end
            MODE_SELECT: begin
                if (sel < CONSOLES) begin
                    active_console = CONS_W'(sel);
                end
            end
            default: begin
            end
        endcase
        if (plain) begin
            queue_result(1'b0, 0, '0, 1'b0, 1'b1);
        end
    endtask

    // Compare one result transaction with the oldest prediction.
    task automatic check_result();
        console_result_t want;
        if (display_queue.size() == 0) begin
            report_mismatch("result with nothing expected, cursor", m_cursor_cell, '0);
        end else begin
            want = display_queue.pop_front();
            check_field("write_enable", m_write_enable, want.write_enable);
            check_field("write_address", m_write_address, want.write_address);
            check_field("write_char", m_write_char, want.write_char);
            check_field("write_attr", m_write_attr, want.write_attr);
            check_field("clear_request", m_clear_request, want.clear_request);
            check_field("cursor_cell", m_cursor_cell, want.cursor_cell);
            check_field("view_start", m_view_start, want.view_start);
            check_field("last", m_last, want.last);
        end
    endtask

    initial begin
        error_count     = 0;
        results_pending = 0;
    end

    // Register writes, then inputs, then results, all sampled at the rising edge.
    always @(posedge aclk) begin
        if (!aresetn) begin
            first_cells    = FIRST_REGION_RESET;
            other_cells    = OTHER_REGION_RESET;
            attribute      = ATTR_RESET;
            active_console = '0;
            for (int k = 0; k < CONSOLES; k++) begin
                cursor_pos[k] = '0;
                view_off[k]   = '0;
            end
            display_queue.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_FIRST_REGION: first_cells = cfg_data;
                    REG_OTHER_REGION: other_cells = cfg_data;
                    REG_TEXT_ATTR:    attribute   = ATTR_W'(cfg_data);
                    default: begin
                    end
                endcase
            end
            if (s_valid && s_ready) begin
                predict_key(s_mode, s_char_code, s_console_select);
            end
            if (m_valid && m_ready) begin
                check_result();
            end
        end
        results_pending <= display_queue.size();
    end

endmodule

// ===== tb/tb_text_console_cursor_engine.sv =====
// Top of the text console cursor engine testbench: clock, reset, register writes, keystroke
// stimulus with random idling and the final verdict. Depends on tcce_pkg, the engine and
// tcce_result_checker.
module tb_text_console_cursor_engine;
    timeunit 1ns;
    timeprecision 1ps;
    import tcce_pkg::*;

    localparam int unsigned TIMEOUT_CYCLES = 400000;
    localparam int unsigned SETTLE_CYCLES  = 10;
    localparam int unsigned PHASES         = 6;
    localparam int unsigned PHASE_KEYS     = 16;

    // Mode codes that the engine treats as no operation.
    localparam logic [MODE_W-1:0] MODE_SPARE_LOW  = 4'd14;
    localparam logic [MODE_W-1:0] MODE_SPARE_HIGH = 4'd15;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_kind_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [MODE_W-1:0]    s_mode;
    logic [CHAR_W-1:0]    s_char_code;
    logic [SEL_W-1:0]     s_console_select;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic                 m_write_enable;
    logic [CELL_W-1:0]    m_write_address;
    logic [CHAR_W-1:0]    m_write_char;
    logic [ATTR_W-1:0]    m_write_attr;
    logic                 m_clear_request;
    logic [CELL_W-1:0]    m_cursor_cell;
    logic [CELL_W-1:0]    m_view_start;
    logic                 m_last;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    int unsigned mismatch_total;
    int unsigned results_waiting;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned cycle_count;

    text_console_cursor_engine u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_mode           (s_mode),
        .s_char_code      (s_char_code),
        .s_console_select (s_console_select),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_write_enable   (m_write_enable),
        .m_write_address  (m_write_address),
        .m_write_char     (m_write_char),
        .m_write_attr     (m_write_attr),
        .m_clear_request  (m_clear_request),
        .m_cursor_cell    (m_cursor_cell),
        .m_view_start     (m_view_start),
        .m_last           (m_last),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    tcce_result_checker u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_mode           (s_mode),
        .s_char_code      (s_char_code),
        .s_console_select (s_console_select),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_write_enable   (m_write_enable),
        .m_write_address  (m_write_address),
        .m_write_char     (m_write_char),
        .m_write_attr     (m_write_attr),
        .m_clear_request  (m_clear_request),
        .m_cursor_cell    (m_cursor_cell),
        .m_view_start     (m_view_start),
        .m_last           (m_last),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .error_count      (mismatch_total),
        .results_pending  (results_waiting)
    );

    // Clock.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > TIMEOUT_CYCLES) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // The display side stalls at random while a stall rate is set.
    always @(negedge aclk) begin
        m_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic set_idling(input idle_kind_t kind);
        send_idle_pct  = (kind == IDLE_SENDER) ? 47 : (kind == IDLE_BOTH) ? 35 : 0;
        recv_stall_pct = (kind == IDLE_RECEIVER) ? 47 : (kind == IDLE_BOTH) ? 35 : 0;
    endtask

    // Offer one keystroke transaction and hold it until it is taken.
    task automatic send_key(input logic [MODE_W-1:0] mode, input logic [CHAR_W-1:0] ch,
                            input logic [SEL_W-1:0] sel);
        @(negedge aclk);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid          <= 1'b1;
        s_mode           <= mode;
        s_char_code      <= ch;
        s_console_select <= sel;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Keystroke with random character and console fields.
    task automatic send_mode(input logic [MODE_W-1:0] mode);
        send_key(mode, CHAR_W'($urandom_range(255)), SEL_W'($urandom_range(3)));
    endtask

    // Let every expected result arrive and the pipeline empty.
    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        wait (results_waiting == 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_register(input cfg_reg_t idx, input logic [CFG_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Random keystroke, weighted towards moves that advance the cursor down the region.
    task automatic send_random_key();
        int unsigned roll;
        logic [CHAR_W-1:0] ch;
        roll = $urandom_range(99);
        ch = ($urandom_range(15) == 0) ? NEWLINE_CHAR : CHAR_W'($urandom_range(255));
        if (roll < 25) begin
            send_key(MODE_CHAR, ch, SEL_W'($urandom_range(3)));
        end else if (roll < 45) begin
            send_mode(MODE_NEWLINE);
        end else if (roll < 55) begin
            send_mode(MODE_DOWN);
        end else if (roll < 63) begin
            send_mode(MODE_TAB);
        end else if (roll < 67) begin
            send_mode(MODE_BACKSPACE);
        end else if (roll < 71) begin
            send_mode(MODE_DELETE);
        end else if (roll < 75) begin
            send_mode(MODE_UP);
        end else if (roll < 79) begin
            send_mode(MODE_LEFT);
        end else if (roll < 83) begin
            send_mode(MODE_RIGHT);
        end else if (roll < 86) begin
            send_mode(MODE_HOME);
        end else if (roll < 89) begin
            send_mode(MODE_END);
        end else if (roll < 93) begin
            send_mode(MODE_SCROLL_UP);
        end else if (roll < 97) begin
            send_mode(MODE_SCROLL_DOWN);
        end else if (roll < 99) begin
            send_mode(MODE_SELECT);
        end else begin
            send_mode($urandom_range(1) ? MODE_SPARE_HIGH : MODE_SPARE_LOW);
        end
    endtask

    // Stimulus and verdict.
    initial begin
        logic [CFG_W-1:0]  first_cells;
        logic [CFG_W-1:0]  other_cells;
        logic [ATTR_W-1:0] attr;
        cycle_count      = 0;
        aresetn          = 1'b0;
        s_valid          = 1'b0;
        s_mode           = MODE_CHAR;
        s_char_code      = '0;
        s_console_select = '0;
        cfg_valid        = 1'b0;
        cfg_index        = REG_FIRST_REGION;
        cfg_data         = '0;
        set_idling(IDLE_NONE);
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Every operation at least once at the reset register values, character extremes included.
        send_key(MODE_CHAR, 8'h00, 2'd0);
        send_key(MODE_CHAR, 8'hFF, 2'd3);
        send_key(MODE_CHAR, NEWLINE_CHAR, 2'd0);
        send_mode(MODE_NEWLINE);
        send_mode(MODE_BACKSPACE);
        send_mode(MODE_DELETE);
        send_mode(MODE_UP);
        send_mode(MODE_DOWN);
        send_mode(MODE_LEFT);
        send_mode(MODE_RIGHT);
        send_mode(MODE_HOME);
        send_mode(MODE_END);
        send_mode(MODE_TAB);
        send_mode(MODE_SCROLL_UP);
        send_mode(MODE_SCROLL_DOWN);
        send_key(MODE_SELECT, 8'h00, 2'd2);
        send_key(MODE_SELECT, 8'hFF, 2'd0);
        send_mode(MODE_SPARE_LOW);
        send_mode(MODE_SPARE_HIGH);

        // A three-cell region: wrap on a character and on a newline, clamped delete and a
        // refused move to the right.
        settle();
        write_register(REG_FIRST_REGION, 15'd3);
        repeat (4) send_key(MODE_CHAR, 8'h41, 2'd0);
        send_mode(MODE_DELETE);
        send_mode(MODE_DELETE);
        send_mode(MODE_RIGHT);
        send_mode(MODE_NEWLINE);

        // Random phases, each with its own region layout and attribute; the idling kind cycles through all four.
        for (int phase = 0; phase < PHASES; phase++) begin
            unique case (phase)
                0: begin first_cells = 15'd2100;  other_cells = 15'd2100;  attr = 8'h3C; end
                1: begin first_cells = 15'd1;     other_cells = 15'd1;     attr = 8'h00; end
                2: begin first_cells = 15'd16384; other_cells = 15'd16384; attr = 8'hFF; end
                3: begin first_cells = 15'd0;     other_cells = 15'd32767; attr = 8'hA5; end
                4: begin first_cells = 15'd80;    other_cells = 15'd4000;  attr = 8'h5A; end
                default: begin
                    first_cells = 15'd16383;
                    other_cells = 15'd100;
                    attr = 8'h81;
                end
            endcase
            settle();
            write_register(REG_FIRST_REGION, first_cells);
            write_register(REG_OTHER_REGION, other_cells);
            write_register(REG_TEXT_ATTR, CFG_W'(attr));
            set_idling(idle_kind_t'(phase % 4));
            repeat (PHASE_KEYS) send_random_key();
        end

        settle();
        if (mismatch_total == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/tcce_pkg.sv
hdl/text_console_cursor_engine.sv
tb/tcce_result_checker.sv
tb/tb_text_console_cursor_engine.sv
